/* rtl/core/yuvds_pkg.sv */
// ============================================================================
// yuvds_pkg
// Shared types and constants for the YUV 4:2:2 decimating downscaler.
// ============================================================================
`default_nettype none

package yuvds_pkg;

    // Register and counter widths
    localparam int REG_W   = 13;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 3;
    localparam int COL_W   = REG_W + 1;   // byte index in a row, row = 2*src_width
    localparam int MACRO_W = REG_W - 1;   // macropixels kept in a row, up to dst_width/2

    // Register reset values
    localparam logic [REG_W-1:0] SRC_WIDTH_RST  = REG_W'(640);
    localparam logic [REG_W-1:0] SRC_HEIGHT_RST = REG_W'(480);
    localparam logic [REG_W-1:0] DST_WIDTH_RST  = REG_W'(160);
    localparam logic [REG_W-1:0] DST_HEIGHT_RST = REG_W'(120);
    localparam logic [REG_W-1:0] STEP_X_RST     = REG_W'(4);
    localparam logic [REG_W-1:0] STEP_Y_RST     = REG_W'(4);

    // Last byte of a 4-byte macropixel
    localparam logic [1:0] SUB_LAST = 2'd3;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_STEP_X     = 3'd4,
        REG_STEP_Y     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] src_width;
        logic [REG_W-1:0] src_height;
        logic [REG_W-1:0] dst_width;
        logic [REG_W-1:0] dst_height;
        logic [REG_W-1:0] step_x;
        logic [REG_W-1:0] step_y;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              size_error;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/yuvds_cfg.sv */
// ============================================================================
// yuvds_cfg
// Configuration register file, written through a plain write port.
// ============================================================================
`default_nettype none

module yuvds_cfg
    import yuvds_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Write the addressed register; ignore indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= SRC_WIDTH_RST;
            cfg_reg.src_height <= SRC_HEIGHT_RST;
            cfg_reg.dst_width  <= DST_WIDTH_RST;
            cfg_reg.dst_height <= DST_HEIGHT_RST;
            cfg_reg.step_x     <= STEP_X_RST;
            cfg_reg.step_y     <= STEP_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_data;
                REG_SRC_HEIGHT: cfg_reg.src_height <= cfg_data;
                REG_DST_WIDTH:  cfg_reg.dst_width  <= cfg_data;
                REG_DST_HEIGHT: cfg_reg.dst_height <= cfg_data;
                REG_STEP_X:     cfg_reg.step_x     <= cfg_data;
                REG_STEP_Y:     cfg_reg.step_y     <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/yuvds_ctrl.sv */
// ============================================================================
// yuvds_ctrl
// Raster position counters and keep/drop decision for each source byte.
// ============================================================================
`default_nettype none

module yuvds_ctrl
    import yuvds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] pixel_byte,
    input  wire logic              frame_start,
    input  wire cfg_t              cfg,
    output logic                   res_valid,
    output result_t                res
);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [REG_W-1:0]   row_reg, row_next;
    logic [REG_W-1:0]   cph_reg, cph_next;
    logic [REG_W-1:0]   rph_reg, rph_next;
    logic [MACRO_W-1:0] km_reg, km_next;
    logic [REG_W-1:0]   kr_reg, kr_next;
    logic               drop_reg, drop_next;

    // Counter values seen by this word, cleared by frame start
    logic [COL_W-1:0]   col_e;
    logic [REG_W-1:0]   row_e, cph_e, rph_e, kr_e;
    logic [MACRO_W-1:0] km_e;
    logic               drop_e;

    logic [REG_W-1:0]   sw, sx, sy;
    logic [COL_W-1:0]   row_len;
    logic [MACRO_W-1:0] macro_per_row;
    logic [1:0]         sub;
    logic               odd_size, row_kept, keep, is_last, row_end;
    logic [COL_W:0]     col_inc;
    logic [REG_W:0]     cph_inc, rph_inc, kr_inc, row_inc;
    logic [MACRO_W:0]   km_inc;

    // Treat zero factors and width as one
    always_comb
    begin
        sw            = (cfg.src_width == '0) ? REG_W'(1) : cfg.src_width;
        sx            = (cfg.step_x == '0) ? REG_W'(1) : cfg.step_x;
        sy            = (cfg.step_y == '0) ? REG_W'(1) : cfg.step_y;
        row_len       = {sw, 1'b0};
        macro_per_row = cfg.dst_width[REG_W-1:1];
        odd_size      = cfg.dst_width[0] | cfg.dst_height[0];
    end

    // Clear the counters on frame start
    always_comb
    begin
        col_e  = frame_start ? '0 : col_reg;
        row_e  = frame_start ? '0 : row_reg;
        cph_e  = frame_start ? '0 : cph_reg;
        rph_e  = frame_start ? '0 : rph_reg;
        km_e   = frame_start ? '0 : km_reg;
        kr_e   = frame_start ? '0 : kr_reg;
        drop_e = frame_start ? 1'b0 : drop_reg;
    end

    // Keep decision for this byte
    always_comb
    begin
        sub      = col_e[1:0];
        row_kept = (rph_e == '0) && (kr_e < cfg.dst_height);
        keep     = row_kept && (cph_e == '0) && (km_e < macro_per_row);
        km_inc   = {1'b0, km_e} + (MACRO_W+1)'(1);
        kr_inc   = {1'b0, kr_e} + (REG_W+1)'(1);
        is_last  = keep && (sub == SUB_LAST)
                   && (km_inc == {1'b0, macro_per_row})
                   && (kr_inc == {1'b0, cfg.dst_height});
        col_inc  = {1'b0, col_e} + (COL_W+1)'(1);
        cph_inc  = {1'b0, cph_e} + (REG_W+1)'(1);
        rph_inc  = {1'b0, rph_e} + (REG_W+1)'(1);
        row_inc  = {1'b0, row_e} + (REG_W+1)'(1);
        row_end  = col_inc >= {1'b0, row_len};
    end

    // Advance the counters and build the result
    always_comb
    begin
        col_next  = col_e;
        row_next  = row_e;
        cph_next  = cph_e;
        rph_next  = rph_e;
        km_next   = km_e;
        kr_next   = kr_e;
        drop_next = drop_e;
        res_valid = 1'b0;
        res       = '0;

        if (frame_start && odd_size)
        begin
            // drop the frame, report one error word
            drop_next      = 1'b1;
            res_valid      = 1'b1;
            res.size_error = 1'b1;
        end
        else if (drop_e || (row_e >= cfg.src_height))
        begin
            drop_next = 1'b1;
        end
        else
        begin
            if (sub == SUB_LAST)
            begin
                if (keep)
                begin
                    km_next = km_inc[MACRO_W-1:0];
                end
                cph_next = (cph_inc >= {1'b0, sx}) ? '0 : cph_inc[REG_W-1:0];
            end

            if (row_end)
            begin
                col_next = '0;
                cph_next = '0;
                km_next  = '0;
                if (row_kept)
                begin
                    kr_next = kr_inc[REG_W-1:0];
                end
                rph_next = (rph_inc >= {1'b0, sy}) ? '0 : rph_inc[REG_W-1:0];
                row_next = row_inc[REG_W-1:0];
                if (row_inc >= {1'b0, cfg.src_height})
                begin
                    drop_next = 1'b1;
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end

            if (is_last)
            begin
                drop_next = 1'b1;
            end

            res_valid = keep;
            res.data  = pixel_byte;
            res.last  = is_last;
        end
    end

    // Hold the counters between accepted words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cph_reg  <= '0;
            rph_reg  <= '0;
            km_reg   <= '0;
            kr_reg   <= '0;
            drop_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            cph_reg  <= cph_next;
            rph_reg  <= rph_next;
            km_reg   <= km_next;
            kr_reg   <= kr_next;
            drop_reg <= drop_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/yuvds_obuf.sv */
// ============================================================================
// yuvds_obuf
// Output register with a skid stage so the input side keeps flowing.
// ============================================================================
`default_nettype none

module yuvds_obuf
    import yuvds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     res_valid,
    input  wire result_t  res,
    output logic          full,
    output logic          out_valid,
    input  wire logic     out_stall,
    output result_t       out_word
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    take;

    // Route new words into the output register or the skid stage
    always_comb
    begin
        take            = main_valid_reg && !out_stall;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!main_valid_reg || take)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

endmodule

`default_nettype wire

/* rtl/core/yuv422_decimating_downscaler_core.sv */
// ============================================================================
// yuv422_decimating_downscaler_core
// Nearest-neighbor YUYV downscaler: keeps whole macropixels on a grid.
// ============================================================================
// A kept byte is registered in the output register, or in the skid stage while the output register is held.
// Throughput: one byte per cycle while in_stall is low; the counter update is a single register stage.
// in_stall rises only when both the output register and skid stage are full.
// Reset clears counters, buffers and loads the default 640x480 -> 160x120 setup.
`default_nettype none

module yuv422_decimating_downscaler_core
    import yuvds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [REG_W-1:0]  cfg_data,
    // source bytes
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] pixel_byte,
    input  wire logic              frame_start,
    // kept bytes
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   last,
    output logic                   size_error
);

    cfg_t    cfg;
    result_t res;
    result_t out_word;
    logic    res_valid;
    logic    accept;

    assign accept = in_valid && !in_stall;

    yuvds_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    yuvds_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_byte  (pixel_byte),
        .frame_start (frame_start),
        .cfg         (cfg),
        .res_valid   (res_valid),
        .res         (res)
    );

    yuvds_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid && accept),
        .res       (res),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign out_byte   = out_word.data;
    assign last       = out_word.last;
    assign size_error = out_word.size_error;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for the YUYV decimating downscaler. Source bytes go in
// through a queue-fed driver and kept words are checked against an in-bench
// scan predictor as they leave. The run mixes directed corner cases with
// random small frames over many register setups, including the extremes,
// and applies random idle gaps and output stalls.
// ============================================================================
`default_nettype none

module tb_top
    import yuvds_pkg::*;
;

    localparam int TARGET_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              sof;
    } src_word_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_we      = 1'b0;
    logic [IDX_W-1:0]  cfg_index   = '0;
    logic [REG_W-1:0]  cfg_data    = '0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] pixel_byte  = '0;
    logic              frame_start = 1'b0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              size_error;

    src_word_t pending_words[$];
    result_t   kept_words[$];
    int        mismatches   = 0;
    int        queued_items = 0;
    bit        no_idle      = 1'b0;
    int        src_gap      = 0;
    int        sink_hold    = 0;
    src_word_t next_word;
    result_t   want;

    // Scan predictor: register copy and frame counters
    cfg_t        scan_cfg;
    int unsigned col_byte, src_row, col_phase, row_phase, macro_kept, rows_kept;
    bit          frame_done;

    yuv422_decimating_downscaler_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_byte  (pixel_byte),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last),
        .size_error  (size_error)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic clear_scan();
        col_byte   = 0;
        src_row    = 0;
        col_phase  = 0;
        row_phase  = 0;
        macro_kept = 0;
        rows_kept  = 0;
        frame_done = 1'b0;
    endtask

    // Advance the scan by one source byte and queue the word it yields, if any
    task automatic predict_downscale(input logic [BYTE_W-1:0] b, input logic sof);
        int unsigned sw, sh, dh, sx, sy, row_len, macros, sub;
        bit          row_on, keep, is_last;
        result_t     r;
        sw      = (scan_cfg.src_width == '0) ? 32'd1 : 32'(scan_cfg.src_width);
        sx      = (scan_cfg.step_x == '0) ? 32'd1 : 32'(scan_cfg.step_x);
        sy      = (scan_cfg.step_y == '0) ? 32'd1 : 32'(scan_cfg.step_y);
        sh      = 32'(scan_cfg.src_height);
        dh      = 32'(scan_cfg.dst_height);
        row_len = 2 * sw;
        macros  = 32'(scan_cfg.dst_width) / 2;
        is_last = 1'b0;

        // Frame start clears the scan; an odd target size rejects the frame
        if (sof)
        begin
            clear_scan();
            if (scan_cfg.dst_width[0] || scan_cfg.dst_height[0])
            begin
                frame_done = 1'b1;
                r.data       = '0;
                r.last       = 1'b0;
                r.size_error = 1'b1;
                kept_words.push_back(r);
                return;
            end
        end
        if (frame_done || src_row >= sh)
        begin
            frame_done = 1'b1;
            return;
        end

        sub    = col_byte & 32'd3;
        row_on = (row_phase == 0) && (rows_kept < dh);
        keep   = row_on && (col_phase == 0) && (macro_kept < macros);
        if (keep && sub == 32'(SUB_LAST) && macro_kept + 1 == macros &&
            rows_kept + 1 == dh)
            is_last = 1'b1;

        // Step the macropixel grid at the end of each 4-byte group
        if (sub == 32'(SUB_LAST))
        begin
            if (keep)
                macro_kept = macro_kept + 1;
            col_phase = (col_phase + 1 >= sx) ? 0 : col_phase + 1;
        end

        // Row end restarts the column counters and steps the row grid
        if (col_byte + 1 >= row_len)
        begin
            col_byte   = 0;
            col_phase  = 0;
            macro_kept = 0;
            if (row_on)
                rows_kept = rows_kept + 1;
            row_phase = (row_phase + 1 >= sy) ? 0 : row_phase + 1;
            src_row   = src_row + 1;
            if (src_row >= sh)
                frame_done = 1'b1;
        end
        else
        begin
            col_byte = col_byte + 1;
        end

        if (is_last)
            frame_done = 1'b1;
        if (keep)
        begin
            r.data       = b;
            r.last       = is_last;
            r.size_error = 1'b0;
            kept_words.push_back(r);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 99) < 55)
            return 0;
        return pick_len();
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 4096;
            3: return 8191;
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    function automatic cfg_t make_cfg(input int sw, input int sh, input int dw,
                                      input int dh, input int sx, input int sy);
        cfg_t c;
        c.src_width  = REG_W'(sw);
        c.src_height = REG_W'(sh);
        c.dst_width  = REG_W'(dw);
        c.dst_height = REG_W'(dh);
        c.step_x     = REG_W'(sx);
        c.step_y     = REG_W'(sy);
        return c;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            REG_SRC_WIDTH:  scan_cfg.src_width  = v;
            REG_SRC_HEIGHT: scan_cfg.src_height = v;
            REG_DST_WIDTH:  scan_cfg.dst_width  = v;
            REG_DST_HEIGHT: scan_cfg.dst_height = v;
            REG_STEP_X:     scan_cfg.step_x     = v;
            REG_STEP_Y:     scan_cfg.step_y     = v;
            default: ;
        endcase
    endtask

    task automatic load_regs(input cfg_t c);
        write_reg(REG_SRC_WIDTH,  c.src_width);
        write_reg(REG_SRC_HEIGHT, c.src_height);
        write_reg(REG_DST_WIDTH,  c.dst_width);
        write_reg(REG_DST_HEIGHT, c.dst_height);
        write_reg(REG_STEP_X,     c.step_x);
        write_reg(REG_STEP_Y,     c.step_y);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_word(input logic [BYTE_W-1:0] b, input logic sof);
        src_word_t w;
        w.data = b;
        w.sof  = sof;
        pending_words.push_back(w);
        queued_items++;
    endtask

    // Hold until the source queue is empty and every kept word has come out
    task automatic wait_idle();
        int n;
        n = 0;
        while ((pending_words.size() != 0 || in_valid || kept_words.size() != 0) &&
               n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        if (kept_words.size() != 0)
        begin
            note_error($sformatf("%0d kept words never came out", kept_words.size()));
            kept_words.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Source driver: present queued words with random idle gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            pixel_byte  <= '0;
            frame_start <= 1'b0;
            src_gap     <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_downscale(pixel_byte, frame_start);
            if (!in_valid || !in_stall)
            begin
                if (src_gap != 0)
                begin
                    src_gap  <= src_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    pixel_byte  <= next_word.data;
                    frame_start <= next_word.sof;
                    in_valid    <= 1'b1;
                    src_gap     <= pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each accepted word, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_hold <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (kept_words.size() == 0)
                begin
                    note_error($sformatf("unexpected word byte=%h last=%b err=%b",
                                         out_byte, last, size_error));
                end
                else
                begin
                    want = kept_words.pop_front();
                    if (out_byte !== want.data || last !== want.last ||
                        size_error !== want.size_error)
                        note_error($sformatf(
                            "byte=%h last=%b err=%b, expected byte=%h last=%b err=%b",
                            out_byte, last, size_error,
                            want.data, want.last, want.size_error));
                end
            end
            if (sink_hold != 0)
            begin
                sink_hold <= sink_hold - 1;
                out_stall <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 99) < 20)
            begin
                sink_hold <= pick_len() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        cfg_t c;
        int   sw, sh, frames, len;
        scan_cfg = make_cfg(SRC_WIDTH_RST, SRC_HEIGHT_RST, DST_WIDTH_RST,
                            DST_HEIGHT_RST, STEP_X_RST, STEP_Y_RST);
        clear_scan();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Stream with no frame start yet, reset setup: first macropixel kept
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h5A, 1'b0);
        push_word(8'hA5, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'h80, 1'b0);
        wait_idle();

        // Odd destination width, then odd destination height
        load_regs(make_cfg(640, 480, 3, 120, 4, 4));
        push_word(8'h11, 1'b1);
        push_word(8'h22, 1'b0);
        wait_idle();
        load_regs(make_cfg(640, 480, 4, 8191, 4, 4));
        push_word(8'h33, 1'b1);
        wait_idle();

        // Zero width and steps act as one; macropixel runs past the row end
        load_regs(make_cfg(0, 2, 2, 2, 0, 0));
        push_word(8'hC3, 1'b1);
        push_word(8'h3C, 1'b0);
        push_word(8'h7E, 1'b0);
        push_word(8'h81, 1'b0);
        wait_idle();

        // Zero source height drops all; zero destination width keeps nothing
        load_regs(make_cfg(2, 0, 2, 2, 1, 1));
        push_word(8'h44, 1'b1);
        wait_idle();
        load_regs(make_cfg(2, 2, 0, 2, 1, 1));
        push_word(8'h55, 1'b1);
        push_word(8'h66, 1'b0);
        wait_idle();

        // Complete frame marked last, then bytes after the frame is done
        load_regs(make_cfg(2, 2, 2, 2, 1, 1));
        push_word(8'hFF, 1'b1);
        for (int i = 1; i < 8; i++)
            push_word(8'($urandom_range(0, 255)), 1'b0);
        push_word(8'h00, 1'b0);
        wait_idle();

        // Random phases: one register setup, a few frames with random content
        while (queued_items < TARGET_ITEMS + 25)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85)
            begin
                sw = $urandom_range(0, 10);
                sh = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
                c = make_cfg(sw, sh, 2 * $urandom_range(1, 6), 2 * $urandom_range(1, 3),
                             $urandom_range(0, 4), $urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0)
                    c.dst_width = c.dst_width + REG_W'(1);
                else if ($urandom_range(0, 19) == 0)
                    c.dst_width = '0;
                if ($urandom_range(0, 11) == 0)
                    c.dst_height = c.dst_height + REG_W'(1);
                len = 2 * ((sw == 0) ? 1 : sw) * ((sh == 0) ? 1 : sh);
            end
            else
            begin
                c = make_cfg(pick_extreme(), pick_extreme(), pick_extreme(),
                             pick_extreme(), pick_extreme(), pick_extreme());
                len = $urandom_range(20, 200);
            end
            load_regs(c);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                // Mostly exact frames; some cut short or overrun
                if ($urandom_range(0, 99) < 15)
                    len = $urandom_range(1, len + 8);
                for (int i = 0; i < len; i++)
                begin
                    if (i == 0)
                        push_word(8'($urandom_range(0, 255)), $urandom_range(0, 19) != 0);
                    else
                        push_word(8'($urandom_range(0, 255)), $urandom_range(0, 99) == 0);
                end
            end
            wait_idle();
        end

        no_idle = 1'b0;
        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/yuvds_pkg.sv
rtl/core/yuvds_cfg.sv
rtl/core/yuvds_ctrl.sv
rtl/core/yuvds_obuf.sv
rtl/core/yuv422_decimating_downscaler_core.sv
sim/tb_top.sv
